[sv/red_queue_admission_assert.svh]
// assertion macros for the red queue admission block
// included by files that check their own logic; no other dependencies
`ifndef RED_QUEUE_ADMISSION_ASSERT_SVH
`define RED_QUEUE_ADMISSION_ASSERT_SVH

`ifndef ASSERT_OFF

// expression holds at every clock edge out of reset
`define RQA_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("rqa assertion failed");

// consequent holds in the same cycle as the antecedent
`define RQA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rqa assertion failed");

// consequent holds in the cycle after the antecedent
`define RQA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rqa assertion failed");

`else

`define RQA_ASSERT_ALWAYS(label, clk, rst, expr)
`define RQA_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define RQA_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[sv/rqa_pkg.sv]
// shared widths, codes, reset values and control types of the red queue admission block
// used by rqa_ctrl, rqa_datapath and red_queue_admission; no dependencies
package rqa_pkg;

   // field and state widths
   localparam int OCC_W      = 8;
   localparam int CNT_W      = 16;
   localparam int FRAC_W     = 16;
   localparam int AVG_W      = OCC_W + FRAC_W;
   localparam int PROB_W     = 17;
   localparam int WEIGHT_W   = 16;
   localparam int RND_W      = 7;
   localparam int CMD_W      = 2;
   localparam int REASON_W   = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;
   localparam int PCT_W      = 7;

   // request command codes
   localparam logic [CMD_W-1:0] CMD_ARRIVAL   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DEPARTURE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TICK      = 2'd2;
   localparam logic [CMD_W-1:0] CMD_INTERVAL  = 2'd3;

   // drop reason codes
   localparam logic [REASON_W-1:0] DROP_NONE   = 2'd0;
   localparam logic [REASON_W-1:0] DROP_FULL   = 2'd1;
   localparam logic [REASON_W-1:0] DROP_EARLY  = 2'd2;
   localparam logic [REASON_W-1:0] DROP_FORCED = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_THRESHOLD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_THRESHOLD = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DROP_PROB = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_AVG_WEIGHT    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BUFFER_LIMIT  = 3'd4;

   // register reset values
   localparam logic [OCC_W-1:0]    RST_MIN_THRESHOLD = 8'd5;
   localparam logic [OCC_W-1:0]    RST_MAX_THRESHOLD = 8'd15;
   localparam logic [PROB_W-1:0]   RST_MAX_DROP_PROB = 17'd6554;
   localparam logic [WEIGHT_W-1:0] RST_AVG_WEIGHT    = 16'd131;
   localparam logic [OCC_W-1:0]    RST_BUFFER_LIMIT  = 8'd35;

   // fixed point constants
   localparam logic [FRAC_W:0]   Q16_ONE       = {1'b1, {FRAC_W{1'b0}}};
   localparam logic [FRAC_W-1:0] Q16_HALF      = {1'b1, {(FRAC_W-1){1'b0}}};
   localparam logic [PCT_W-1:0]  PERCENT_SCALE = 7'd100;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load_req;
      logic run_stage1;
      logic run_stage2;
      logic commit;
   } ctrl_cmd_type;

endpackage

[sv/red_queue_admission.sv]
// top level of the red queue admission block: controller, datapath and checks
// depends on rqa_pkg, rqa_ctrl, rqa_datapath and red_queue_admission_assert.svh
//
// Random early detection admission for a packet buffer. Each request carries a
// command (arrival, departure, average tick, interval end) and a random percent;
// each request produces exactly one response with the admission result, the
// occupancy, the Q16 average and the three interval totals.
// Channels: req_* in and rsp_* out use valid/stall; a transfer happens on a
// clock edge with valid high and stall low. csr_* is a write-only register
// port; the user must write it only while no request is in flight, and the
// block does not enforce this. After a request is accepted it runs the two
// multiply stages and then the commit, which loads the response register and
// raises response valid; no new request is taken until the commit is done.
// A new request is taken while the previous response waits in the output
// register; a stalled response holds the next request in its commit stage.
// Reset: synchronous, active high; clears the queue state and counters and
// loads the register defaults; no response is pending after reset.
`include "red_queue_admission_assert.svh"
module red_queue_admission (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [rqa_pkg::CMD_W-1:0]            req_cmd,
   input  logic [rqa_pkg::RND_W-1:0]            req_random_percent,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_accepted,
   output logic [rqa_pkg::REASON_W-1:0]         rsp_drop_reason,
   output logic                                 rsp_empty_departure,
   output logic [rqa_pkg::OCC_W-1:0]            rsp_occupancy,
   output logic [rqa_pkg::AVG_W-1:0]            rsp_average_queue_q16,
   output logic [rqa_pkg::CNT_W-1:0]            rsp_drop_total,
   output logic [rqa_pkg::CNT_W-1:0]            rsp_arrival_total,
   output logic [rqa_pkg::CNT_W-1:0]            rsp_departure_total,
   input  logic                                 csr_write_enable,
   input  logic [rqa_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [rqa_pkg::CSR_DATA_W-1:0]       csr_write_data
);

   rqa_pkg::ctrl_cmd_type ctrl_cmd;

   // sequencer
   rqa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctrl_cmd  (ctrl_cmd)
   );

   // arithmetic, state and response register
   rqa_datapath u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .ctrl_cmd              (ctrl_cmd),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data),
      .req_cmd               (req_cmd),
      .req_random_percent    (req_random_percent),
      .rsp_accepted          (rsp_accepted),
      .rsp_drop_reason       (rsp_drop_reason),
      .rsp_empty_departure   (rsp_empty_departure),
      .rsp_occupancy         (rsp_occupancy),
      .rsp_average_queue_q16 (rsp_average_queue_q16),
      .rsp_drop_total        (rsp_drop_total),
      .rsp_arrival_total     (rsp_arrival_total),
      .rsp_departure_total   (rsp_departure_total)
   );

   // checks on the sequencing and the response contents
   `RQA_ASSERT_ALWAYS(a_one_step, clock, reset, $onehot0(ctrl_cmd))
   `RQA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `RQA_ASSERT_IMPLY(a_accept_no_reason, clock, reset, rsp_valid && rsp_accepted, rsp_drop_reason == rqa_pkg::DROP_NONE)
   `RQA_ASSERT_IMPLY(a_empty_zero_occ, clock, reset, rsp_valid && rsp_empty_departure, rsp_occupancy == '0)

endmodule

[sv/rqa_ctrl.sv]
// controller of the red queue admission block: sequences one request
// through capture, two multiply stages and commit; uses rqa_pkg
module rqa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rqa_pkg::ctrl_cmd_type ctrl_cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL1,
      ST_MUL2,
      ST_COMMIT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   // output register can take a new result
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // command decode and next state
   always_comb begin
      ctrl_cmd            = '0;
      state_in            = state_ff;
      ctrl_cmd.load_req   = (state_ff == ST_IDLE) && req_valid;
      ctrl_cmd.run_stage1 = (state_ff == ST_MUL1);
      ctrl_cmd.run_stage2 = (state_ff == ST_MUL2);
      ctrl_cmd.commit     = (state_ff == ST_COMMIT) && out_free;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_MUL1;
         end
         ST_MUL1: state_in = ST_MUL2;
         ST_MUL2: state_in = ST_COMMIT;
         ST_COMMIT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // response valid follows commit and the downstream take
   always_comb begin
      priority if (ctrl_cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

[sv/rqa_datapath.sv]
// datapath of the red queue admission block: registers, queue state,
// average and early drop multiplies, decision and response register; uses rqa_pkg
module rqa_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  rqa_pkg::ctrl_cmd_type                ctrl_cmd,
   input  logic                                 csr_write_enable,
   input  logic [rqa_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [rqa_pkg::CSR_DATA_W-1:0]       csr_write_data,
   input  logic [rqa_pkg::CMD_W-1:0]            req_cmd,
   input  logic [rqa_pkg::RND_W-1:0]            req_random_percent,
   output logic                                 rsp_accepted,
   output logic [rqa_pkg::REASON_W-1:0]         rsp_drop_reason,
   output logic                                 rsp_empty_departure,
   output logic [rqa_pkg::OCC_W-1:0]            rsp_occupancy,
   output logic [rqa_pkg::AVG_W-1:0]            rsp_average_queue_q16,
   output logic [rqa_pkg::CNT_W-1:0]            rsp_drop_total,
   output logic [rqa_pkg::CNT_W-1:0]            rsp_arrival_total,
   output logic [rqa_pkg::CNT_W-1:0]            rsp_departure_total
);

   localparam int KEEP_W = rqa_pkg::FRAC_W + 1 + rqa_pkg::AVG_W;
   localparam int SUM_W  = KEEP_W + 1;
   localparam int NEW_W  = rqa_pkg::WEIGHT_W + rqa_pkg::OCC_W;
   localparam int EX_W   = rqa_pkg::AVG_W + rqa_pkg::PCT_W;
   localparam int RS_W   = rqa_pkg::RND_W + rqa_pkg::OCC_W;
   localparam int DROP_W = EX_W + rqa_pkg::PROB_W;
   localparam int LHS_W  = RS_W + 2 * rqa_pkg::FRAC_W;

   // configuration registers
   logic [rqa_pkg::OCC_W-1:0]    min_thr_ff;
   logic [rqa_pkg::OCC_W-1:0]    max_thr_ff;
   logic [rqa_pkg::PROB_W-1:0]   max_prob_ff;
   logic [rqa_pkg::WEIGHT_W-1:0] weight_ff;
   logic [rqa_pkg::OCC_W-1:0]    limit_ff;

   // queue state
   logic [rqa_pkg::OCC_W-1:0] queue_ff;
   logic [rqa_pkg::OCC_W-1:0] queue_in;
   logic [rqa_pkg::AVG_W-1:0] avg_ff;
   logic [rqa_pkg::AVG_W-1:0] avg_in;
   logic [rqa_pkg::CNT_W-1:0] drops_ff;
   logic [rqa_pkg::CNT_W-1:0] drops_in;
   logic [rqa_pkg::CNT_W-1:0] arrivals_ff;
   logic [rqa_pkg::CNT_W-1:0] arrivals_in;
   logic [rqa_pkg::CNT_W-1:0] departures_ff;
   logic [rqa_pkg::CNT_W-1:0] departures_in;

   // captured request
   logic [rqa_pkg::CMD_W-1:0] cmd_ff;
   logic [rqa_pkg::RND_W-1:0] rnd_ff;

   // multiply stages
   logic [rqa_pkg::FRAC_W:0]  keep_weight;
   logic [rqa_pkg::AVG_W-1:0] excess;
   logic [rqa_pkg::OCC_W-1:0] span;
   logic [KEEP_W-1:0]         keep_prod_ff;
   logic [NEW_W-1:0]          new_prod_ff;
   logic [EX_W-1:0]           excess100_ff;
   logic [RS_W-1:0]           rs_prod_ff;
   logic [SUM_W-1:0]          avg_sum_ff;
   logic [DROP_W-1:0]         drop_prod_ff;

   // decision
   logic [rqa_pkg::AVG_W-1:0]    min_q16;
   logic [rqa_pkg::AVG_W-1:0]    max_q16;
   logic [LHS_W-1:0]             early_lhs;
   logic                         early_hit;
   logic                         full;
   logic                         acc_in;
   logic [rqa_pkg::REASON_W-1:0] reason_in;
   logic                         empty_in;
   logic [rqa_pkg::CNT_W-1:0]    drops_upd;
   logic [rqa_pkg::CNT_W-1:0]    arrivals_upd;
   logic [rqa_pkg::CNT_W-1:0]    departures_upd;

   // response register
   logic                         acc_ff;
   logic [rqa_pkg::REASON_W-1:0] reason_ff;
   logic                         empty_ff;
   logic [rqa_pkg::OCC_W-1:0]    occ_out_ff;
   logic [rqa_pkg::AVG_W-1:0]    avg_out_ff;
   logic [rqa_pkg::CNT_W-1:0]    drop_tot_ff;
   logic [rqa_pkg::CNT_W-1:0]    arr_tot_ff;
   logic [rqa_pkg::CNT_W-1:0]    dep_tot_ff;

   function automatic logic [rqa_pkg::CNT_W-1:0] sat_inc(input logic [rqa_pkg::CNT_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         min_thr_ff  <= rqa_pkg::RST_MIN_THRESHOLD;
         max_thr_ff  <= rqa_pkg::RST_MAX_THRESHOLD;
         max_prob_ff <= rqa_pkg::RST_MAX_DROP_PROB;
         weight_ff   <= rqa_pkg::RST_AVG_WEIGHT;
         limit_ff    <= rqa_pkg::RST_BUFFER_LIMIT;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            rqa_pkg::CSR_MIN_THRESHOLD: min_thr_ff  <= csr_write_data[rqa_pkg::OCC_W-1:0];
            rqa_pkg::CSR_MAX_THRESHOLD: max_thr_ff  <= csr_write_data[rqa_pkg::OCC_W-1:0];
            rqa_pkg::CSR_MAX_DROP_PROB: max_prob_ff <= csr_write_data[rqa_pkg::PROB_W-1:0];
            rqa_pkg::CSR_AVG_WEIGHT:    weight_ff   <= csr_write_data[rqa_pkg::WEIGHT_W-1:0];
            rqa_pkg::CSR_BUFFER_LIMIT:  limit_ff    <= csr_write_data[rqa_pkg::OCC_W-1:0];
            default: ;
         endcase
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (ctrl_cmd.load_req) begin
         cmd_ff <= req_cmd;
         rnd_ff <= req_random_percent;
      end
   end

   // operands of the first multiply stage
   assign keep_weight = rqa_pkg::Q16_ONE - {1'b0, weight_ff};
   assign min_q16     = {min_thr_ff, {rqa_pkg::FRAC_W{1'b0}}};
   assign max_q16     = {max_thr_ff, {rqa_pkg::FRAC_W{1'b0}}};
   assign excess      = avg_ff - min_q16;
   assign span        = max_thr_ff - min_thr_ff;

   // stage 1: average terms and both sides of the early drop test
   always_ff @(posedge clock) begin
      if (ctrl_cmd.run_stage1) begin
         keep_prod_ff <= KEEP_W'(keep_weight) * KEEP_W'(avg_ff);
         new_prod_ff  <= NEW_W'(weight_ff) * NEW_W'(queue_ff);
         excess100_ff <= EX_W'(excess) * EX_W'(rqa_pkg::PERCENT_SCALE);
         rs_prod_ff   <= RS_W'(rnd_ff) * RS_W'(span);
      end
   end

   // stage 2: rounded average sum and scaled drop probability
   always_ff @(posedge clock) begin
      if (ctrl_cmd.run_stage2) begin
         avg_sum_ff   <= SUM_W'(keep_prod_ff)
                       + SUM_W'({new_prod_ff, {rqa_pkg::FRAC_W{1'b0}}})
                       + SUM_W'(rqa_pkg::Q16_HALF);
         drop_prod_ff <= DROP_W'(excess100_ff) * DROP_W'(max_prob_ff);
      end
   end

   // admission decision and state update
   assign early_lhs = {rs_prod_ff, {(2 * rqa_pkg::FRAC_W){1'b0}}};
   assign early_hit = DROP_W'(early_lhs) <= drop_prod_ff;
   assign full      = (queue_ff >= limit_ff) || (queue_ff == '1);

   always_comb begin
      acc_in         = 1'b0;
      reason_in      = rqa_pkg::DROP_NONE;
      empty_in       = 1'b0;
      queue_in       = queue_ff;
      avg_in         = avg_ff;
      drops_upd      = drops_ff;
      arrivals_upd   = arrivals_ff;
      departures_upd = departures_ff;
      drops_in       = drops_ff;
      arrivals_in    = arrivals_ff;
      departures_in  = departures_ff;
      unique case (cmd_ff)
         rqa_pkg::CMD_ARRIVAL: begin
            arrivals_upd = sat_inc(arrivals_ff);
            priority if (full) begin
               reason_in = rqa_pkg::DROP_FULL;
            end else if (avg_ff < min_q16) begin
               acc_in = 1'b1;
            end else if (avg_ff < max_q16) begin
               if (early_hit) begin
                  reason_in = rqa_pkg::DROP_EARLY;
               end else begin
                  acc_in = 1'b1;
               end
            end else begin
               reason_in = rqa_pkg::DROP_FORCED;
            end
            if (acc_in) begin
               queue_in = queue_ff + 1'b1;
            end else begin
               drops_upd = sat_inc(drops_ff);
            end
         end
         rqa_pkg::CMD_DEPARTURE: begin
            if (queue_ff == '0) begin
               empty_in = 1'b1;
            end else begin
               queue_in       = queue_ff - 1'b1;
               departures_upd = sat_inc(departures_ff);
            end
         end
         rqa_pkg::CMD_TICK: begin
            avg_in = avg_sum_ff[rqa_pkg::FRAC_W +: rqa_pkg::AVG_W];
         end
         rqa_pkg::CMD_INTERVAL: ;
         default: ;
      endcase
      // interval end reports the totals and then clears them
      if (cmd_ff == rqa_pkg::CMD_INTERVAL) begin
         drops_in      = '0;
         arrivals_in   = '0;
         departures_in = '0;
      end else begin
         drops_in      = drops_upd;
         arrivals_in   = arrivals_upd;
         departures_in = departures_upd;
      end
   end

   // queue state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         queue_ff      <= '0;
         avg_ff        <= '0;
         drops_ff      <= '0;
         arrivals_ff   <= '0;
         departures_ff <= '0;
      end else if (ctrl_cmd.commit) begin
         queue_ff      <= queue_in;
         avg_ff        <= avg_in;
         drops_ff      <= drops_in;
         arrivals_ff   <= arrivals_in;
         departures_ff <= departures_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (ctrl_cmd.commit) begin
         acc_ff      <= acc_in;
         reason_ff   <= reason_in;
         empty_ff    <= empty_in;
         occ_out_ff  <= queue_in;
         avg_out_ff  <= avg_in;
         drop_tot_ff <= drops_upd;
         arr_tot_ff  <= arrivals_upd;
         dep_tot_ff  <= departures_upd;
      end
   end

   assign rsp_accepted          = acc_ff;
   assign rsp_drop_reason       = reason_ff;
   assign rsp_empty_departure   = empty_ff;
   assign rsp_occupancy         = occ_out_ff;
   assign rsp_average_queue_q16 = avg_out_ff;
   assign rsp_drop_total        = drop_tot_ff;
   assign rsp_arrival_total     = arr_tot_ff;
   assign rsp_departure_total   = dep_tot_ff;

endmodule
